// File: sv/pedal_to_motor_drive_mapper_macros.svh
// Assertion macros shared by the pedal mapper RTL.
`ifndef PEDAL_TO_MOTOR_DRIVE_MAPPER_MACROS_SVH
`define PEDAL_TO_MOTOR_DRIVE_MAPPER_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define PMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also runs during reset.
`define PMD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: sv/pmd_pkg.sv
// Shared types, widths and codes for the pedal to motor drive mapper.
package pmd_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int DUTY_BITS   = 8;
  localparam int PROD_BITS   = SAMPLE_BITS + DUTY_BITS;
  localparam int CNT_BITS    = $clog2(DUTY_BITS);
  localparam int CFG_BITS    = (SAMPLE_BITS > DUTY_BITS) ? SAMPLE_BITS : DUTY_BITS;
  localparam int CFG_IDX_BITS = 2;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_OFF_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FULL_POINT    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_DUTY      = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_DUTY      = 2'd3;

  // reset values
  localparam logic [SAMPLE_BITS-1:0] RST_OFF_THRESHOLD = SAMPLE_BITS'(205);
  localparam logic [SAMPLE_BITS-1:0] RST_FULL_POINT    = SAMPLE_BITS'(767);
  localparam logic [DUTY_BITS-1:0]   RST_MIN_DUTY      = DUTY_BITS'(127);
  localparam logic [DUTY_BITS-1:0]   RST_MAX_DUTY      = DUTY_BITS'(255);

  // override modes
  localparam logic [1:0] MODE_ANALOG = 2'd0;
  localparam logic [1:0] MODE_FWD    = 2'd1;
  localparam logic [1:0] MODE_REV    = 2'd2;
  localparam logic [1:0] MODE_STOP   = 2'd3;

  // LED codes
  localparam logic [1:0] LED_IDLE = 2'd0;
  localparam logic [1:0] LED_FWD  = 2'd1;
  localparam logic [1:0] LED_REV  = 2'd2;
  localparam logic [1:0] LED_BOTH = 2'd3;

  // command characters (upper case)
  localparam logic [7:0] CMD_FWD    = 8'h46; // F
  localparam logic [7:0] CMD_REV    = 8'h52; // R
  localparam logic [7:0] CMD_STOP   = 8'h53; // S
  localparam logic [7:0] CMD_ANALOG = 8'h41; // A
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] off_threshold;
    logic [SAMPLE_BITS-1:0] full_point;
    logic [DUTY_BITS-1:0]   min_duty;
    logic [DUTY_BITS-1:0]   max_duty;
  } pmd_cfg_t;

  typedef struct packed {
    logic                 done;
    logic [DUTY_BITS-1:0] duty;
  } pmd_lane_st_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] fwd_duty;
    logic [DUTY_BITS-1:0] rev_duty;
    logic [1:0]           led_state;
    logic [1:0]           mode;
  } pmd_res_t;

  // Override mode after an optional command byte; case-insensitive match.
  function automatic logic [1:0] pmd_next_mode(logic [1:0] mode, logic cmd_valid,
                                               logic [7:0] cmd_byte);
    logic [7:0] c;
    logic [1:0] m;
    c = cmd_byte;
    m = mode;
    if (c inside {[CHAR_LC_A:CHAR_LC_Z]}) begin
      c = c - CASE_DELTA;
    end
    if (cmd_valid) begin
      case (c)
        CMD_FWD:    m = MODE_FWD;
        CMD_REV:    m = MODE_REV;
        CMD_STOP:   m = MODE_STOP;
        CMD_ANALOG: m = MODE_ANALOG;
        default:    m = mode;
      endcase
    end
    return m;
  endfunction

endpackage

// File: sv/pmd_lane.sv
// One pedal lane: threshold check, multiply, then a bit-per-cycle restoring divide.
`include "pedal_to_motor_drive_mapper_macros.svh"

module pmd_lane (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [pmd_pkg::SAMPLE_BITS-1:0] sample_i,
  input  pmd_pkg::pmd_cfg_t              cfg_i,
  output pmd_pkg::pmd_lane_st_t          st_o
);
  import pmd_pkg::*;

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_MUL  = 2'd1;
  localparam logic [1:0] L_DIV  = 2'd2;
  localparam logic [1:0] L_DONE = 2'd3;
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DUTY_BITS - 1);

  logic [1:0]             state_q, state_d;
  logic [CNT_BITS-1:0]    cnt_q, cnt_d;
  logic [SAMPLE_BITS-1:0] diff_q, span_q, rem_q, rem_d;
  logic [DUTY_BITS-1:0]   dd_q, lo_q, lo_d, res_q, res_d;
  logic                   down_q;
  logic [PROD_BITS-1:0]   mag;
  logic [SAMPLE_BITS:0]   trial, trial_sub;
  logic                   qbit;
  logic [DUTY_BITS-1:0]   q_next;

  assign mag       = PROD_BITS'(diff_q) * PROD_BITS'(dd_q);
  assign trial     = {rem_q, lo_q[DUTY_BITS-1]};
  assign trial_sub = trial - {1'b0, span_q};
  assign qbit      = (trial >= {1'b0, span_q});
  assign q_next    = {lo_q[DUTY_BITS-2:0], qbit};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    lo_d    = lo_q;
    res_d   = res_q;
    case (state_q)
      L_MUL: begin
        rem_d   = mag[PROD_BITS-1:DUTY_BITS];
        lo_d    = mag[DUTY_BITS-1:0];
        cnt_d   = '0;
        state_d = L_DIV;
      end
      L_DIV: begin
        rem_d = qbit ? trial_sub[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
        lo_d  = q_next;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          res_d   = down_q ? (cfg_i.min_duty - q_next) : (cfg_i.min_duty + q_next);
          state_d = L_DONE;
        end
      end
      default: ;
    endcase
    // a new word restarts the lane from idle or done
    if (start_i) begin
      if (sample_i < cfg_i.off_threshold) begin
        res_d   = '0;
        state_d = L_DONE;
      end else if (sample_i >= cfg_i.full_point) begin
        res_d   = cfg_i.max_duty;
        state_d = L_DONE;
      end else begin
        state_d = L_MUL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    res_q <= res_d;
    if (start_i) begin
      diff_q <= sample_i - cfg_i.off_threshold;
      span_q <= cfg_i.full_point - cfg_i.off_threshold;
      down_q <= (cfg_i.min_duty > cfg_i.max_duty);
      dd_q   <= (cfg_i.min_duty > cfg_i.max_duty) ? (cfg_i.min_duty - cfg_i.max_duty)
                                                  : (cfg_i.max_duty - cfg_i.min_duty);
    end
  end

  assign st_o.done = (state_q == L_DONE);
  assign st_o.duty = res_q;

  `PMD_ASSERT(a_start_when_free, start_i |-> (state_q == L_IDLE || state_q == L_DONE),
              "lane started while busy")
  `PMD_ASSERT(a_rem_below_span, state_q == L_DIV |-> rem_q < span_q,
              "partial remainder not below span")
  `PMD_ASSERT(a_done_holds, (state_q == L_DONE && !start_i) |=> state_q == L_DONE,
              "lane dropped done without a new word")

endmodule

// File: sv/pmd_merge.sv
// Merge stage: applies override mode and forward priority to the lane duties.
module pmd_merge (
  input  logic [1:0]                    mode_i,
  input  logic [pmd_pkg::DUTY_BITS-1:0] fwd_duty_i,
  input  logic [pmd_pkg::DUTY_BITS-1:0] rev_duty_i,
  output pmd_pkg::pmd_res_t             res_o
);
  import pmd_pkg::*;

  logic fwd_on, rev_on;

  assign fwd_on = (fwd_duty_i != '0);
  assign rev_on = (rev_duty_i != '0);

  always_comb begin
    res_o.fwd_duty  = '0;
    res_o.rev_duty  = '0;
    res_o.led_state = LED_IDLE;
    res_o.mode      = mode_i;
    case (mode_i)
      MODE_FWD: begin
        res_o.fwd_duty  = '1;
        res_o.led_state = LED_FWD;
      end
      MODE_REV: begin
        res_o.rev_duty  = '1;
        res_o.led_state = LED_REV;
      end
      MODE_ANALOG: begin
        // forward wins when both pedals are pressed
        if (fwd_on) begin
          res_o.fwd_duty  = fwd_duty_i;
          res_o.led_state = rev_on ? LED_BOTH : LED_FWD;
        end else if (rev_on) begin
          res_o.rev_duty  = rev_duty_i;
          res_o.led_state = LED_REV;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: sv/pedal_to_motor_drive_mapper.sv
// Top level: maps two pedal samples and a command byte to motor duty values.
//
// Input channel (in_valid_i/in_ready_o) takes one word at a time: an optional
// command byte and forward/reverse pedal samples. Output channel
// (out_valid_o/out_ready_i) returns one word per input: both duties, the LED
// code and the override mode after the command.
// Config: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 off threshold,
// 1 full point, 2 min duty, 3 max duty); write only while idle.
// Two identical lanes, one per pedal, run in parallel; each does a threshold
// check, a 10x8 multiply and a restoring divide of 8 steps. A merge stage then
// applies the override mode and forward priority.
// Path from input accept to output: a word outside the ramp goes straight
// to the output load; an interpolating one passes multiply, 8 divide steps,
// output load and handoff. One word is worked at a time; the next input is
// taken only once the last has been loaded into the output register.
// The output register holds a finished word; a new input word is accepted
// while it waits. If the receiver stalls, the next result stays in the
// lanes and in_ready_o stays low until the output register frees up.
// Reset: override mode returns to analog, registers to 205/767/127/255,
// both channels go empty.
`include "pedal_to_motor_drive_mapper_macros.svh"

module pedal_to_motor_drive_mapper (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write port
  input  logic                             cfg_we_i,
  input  logic [pmd_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [pmd_pkg::CFG_BITS-1:0]     cfg_data_i,
  // input word
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             cmd_valid_i,
  input  logic [7:0]                       cmd_byte_i,
  input  logic [pmd_pkg::SAMPLE_BITS-1:0]  fwd_sample_i,
  input  logic [pmd_pkg::SAMPLE_BITS-1:0]  rev_sample_i,
  // output word
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [pmd_pkg::DUTY_BITS-1:0]    fwd_duty_o,
  output logic [pmd_pkg::DUTY_BITS-1:0]    rev_duty_o,
  output logic [1:0]                       led_state_o,
  output logic [1:0]                       mode_out_o
);
  import pmd_pkg::*;

  pmd_cfg_t     cfg_q;
  logic [1:0]   mode_q;
  logic         busy_q;
  logic         out_valid_q;
  pmd_res_t     out_q, merged;
  pmd_lane_st_t fwd_st, rev_st;
  logic         accept, load;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;
  // lanes finished and output register free (or being drained)
  assign load       = busy_q && fwd_st.done && rev_st.done && (!out_valid_q || out_ready_i);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.off_threshold <= RST_OFF_THRESHOLD;
      cfg_q.full_point    <= RST_FULL_POINT;
      cfg_q.min_duty      <= RST_MIN_DUTY;
      cfg_q.max_duty      <= RST_MAX_DUTY;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OFF_THRESHOLD: cfg_q.off_threshold <= cfg_data_i[SAMPLE_BITS-1:0];
        REG_FULL_POINT:    cfg_q.full_point    <= cfg_data_i[SAMPLE_BITS-1:0];
        REG_MIN_DUTY:      cfg_q.min_duty      <= cfg_data_i[DUTY_BITS-1:0];
        REG_MAX_DUTY:      cfg_q.max_duty      <= cfg_data_i[DUTY_BITS-1:0];
        default: ;
      endcase
    end
  end

  // mode update happens at accept; mode_q then rides with the word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_ANALOG;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        mode_q <= pmd_next_mode(mode_q, cmd_valid_i, cmd_byte_i);
        busy_q <= 1'b1;
      end else if (load) begin
        busy_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= merged;
    end
  end

  pmd_lane u_fwd_lane (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .sample_i (fwd_sample_i),
    .cfg_i    (cfg_q),
    .st_o     (fwd_st)
  );

  pmd_lane u_rev_lane (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .sample_i (rev_sample_i),
    .cfg_i    (cfg_q),
    .st_o     (rev_st)
  );

  pmd_merge u_merge (
    .mode_i     (mode_q),
    .fwd_duty_i (fwd_st.duty),
    .rev_duty_i (rev_st.duty),
    .res_o      (merged)
  );

  assign out_valid_o = out_valid_q;
  assign fwd_duty_o  = out_q.fwd_duty;
  assign rev_duty_o  = out_q.rev_duty;
  assign led_state_o = out_q.led_state;
  assign mode_out_o  = out_q.mode;

  `PMD_ASSERT(a_one_motor_dir, out_valid_o |-> (fwd_duty_o == '0 || rev_duty_o == '0),
              "both motor directions driven")
  `PMD_ASSERT(a_stop_led_idle, (out_valid_o && mode_out_o == MODE_STOP) |->
              led_state_o == LED_IDLE, "stop mode with lit LED")
  `PMD_ASSERT(a_one_in_flight, accept |=> !in_ready_o,
              "second word accepted while one is in work")

endmodule

// File: tb/pmd_drive_checker.sv
// Monitor for the pedal mapper: predicts each drive word and compares it with the output.
module pmd_drive_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pmd_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [pmd_pkg::CFG_BITS-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic                                cmd_valid_i,
  input  logic [7:0]                          cmd_byte_i,
  input  logic [pmd_pkg::SAMPLE_BITS-1:0]     fwd_sample_i,
  input  logic [pmd_pkg::SAMPLE_BITS-1:0]     rev_sample_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [pmd_pkg::DUTY_BITS-1:0]       fwd_duty_i,
  input  logic [pmd_pkg::DUTY_BITS-1:0]       rev_duty_i,
  input  logic [1:0]                          led_state_i,
  input  logic [1:0]                          mode_out_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import pmd_pkg::*;

  pmd_cfg_t   ramp;
  logic [1:0] drive_mode;
  pmd_res_t   drive_expected[$];
  int         fails = 0;
  int         pend = 0;

  assign fail_count_o = fails;
  assign pending_o    = pend;

  task automatic report_mismatch(input string msg);
    if (fails < 100) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
    fails++;
  endtask

  // Duty for one pedal sample on the current ramp.
  function automatic logic [DUTY_BITS-1:0] ramp_duty(input logic [SAMPLE_BITS-1:0] s,
                                                     input pmd_cfg_t c);
    logic [SAMPLE_BITS-1:0] span;
    logic [PROD_BITS-1:0]   mag;
    logic [PROD_BITS-1:0]   q;
    if (s < c.off_threshold) begin
      return '0;
    end
    if (s >= c.full_point) begin
      return c.max_duty;
    end
    span = c.full_point - c.off_threshold;
    if (c.max_duty >= c.min_duty) begin
      mag = PROD_BITS'(s - c.off_threshold) * PROD_BITS'(c.max_duty - c.min_duty);
      q   = mag / PROD_BITS'(span);
      return DUTY_BITS'(c.min_duty + q);
    end
    // ramp runs downward
    mag = PROD_BITS'(s - c.off_threshold) * PROD_BITS'(c.min_duty - c.max_duty);
    q   = mag / PROD_BITS'(span);
    return DUTY_BITS'(c.min_duty - q);
  endfunction

  function automatic pmd_res_t predict_drive(input logic [1:0] mode,
                                             input logic [SAMPLE_BITS-1:0] fs,
                                             input logic [SAMPLE_BITS-1:0] rs,
                                             input pmd_cfg_t c);
    pmd_res_t             r;
    logic [DUTY_BITS-1:0] fd;
    logic [DUTY_BITS-1:0] rd;
    r           = '0;
    r.led_state = LED_IDLE;
    r.mode      = mode;
    case (mode)
      MODE_FWD: begin
        r.fwd_duty  = '1;
        r.led_state = LED_FWD;
      end
      MODE_REV: begin
        r.rev_duty  = '1;
        r.led_state = LED_REV;
      end
      MODE_ANALOG: begin
        fd = ramp_duty(fs, c);
        rd = ramp_duty(rs, c);
        if (fd != '0 && rd != '0) begin
          r.fwd_duty  = fd;
          r.led_state = LED_BOTH;
        end else if (fd != '0) begin
          r.fwd_duty  = fd;
          r.led_state = LED_FWD;
        end else if (rd != '0) begin
          r.rev_duty  = rd;
          r.led_state = LED_REV;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pmd_res_t   got;
    pmd_res_t   want;
    logic [7:0] cmd_char;
    if (!rst_ni) begin
      ramp       = '{RST_OFF_THRESHOLD, RST_FULL_POINT, RST_MIN_DUTY, RST_MAX_DUTY};
      drive_mode = MODE_ANALOG;
      drive_expected.delete();
      pend = 0;
    end else begin
      // output first: a word leaving now always belongs to an older input
      if (out_valid_i && out_ready_i) begin
        got = '{fwd_duty_i, rev_duty_i, led_state_i, mode_out_i};
        if (drive_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected word fwd=%0d rev=%0d led=%0d mode=%0d",
                                    got.fwd_duty, got.rev_duty, got.led_state, got.mode));
        end else begin
          want = drive_expected.pop_front();
          if (got.fwd_duty !== want.fwd_duty || got.rev_duty !== want.rev_duty ||
              got.led_state !== want.led_state || got.mode !== want.mode) begin
            report_mismatch($sformatf(
              "fwd=%0d/%0d rev=%0d/%0d led=%0d/%0d mode=%0d/%0d (got/exp)",
              got.fwd_duty, want.fwd_duty, got.rev_duty, want.rev_duty,
              got.led_state, want.led_state, got.mode, want.mode));
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_OFF_THRESHOLD: ramp.off_threshold = cfg_data_i[SAMPLE_BITS-1:0];
          REG_FULL_POINT:    ramp.full_point    = cfg_data_i[SAMPLE_BITS-1:0];
          REG_MIN_DUTY:      ramp.min_duty      = cfg_data_i[DUTY_BITS-1:0];
          REG_MAX_DUTY:      ramp.max_duty      = cfg_data_i[DUTY_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (cmd_valid_i) begin
          cmd_char = cmd_byte_i;
          if (cmd_char inside {[CHAR_LC_A:CHAR_LC_Z]}) begin
            cmd_char = cmd_char - CASE_DELTA;
          end
          case (cmd_char)
            CMD_FWD:    drive_mode = MODE_FWD;
            CMD_REV:    drive_mode = MODE_REV;
            CMD_STOP:   drive_mode = MODE_STOP;
            CMD_ANALOG: drive_mode = MODE_ANALOG;
            default: ;
          endcase
        end
        drive_expected.push_back(predict_drive(drive_mode, fwd_sample_i, rev_sample_i, ramp));
      end
      pend = drive_expected.size();
    end
  end

endmodule

// File: tb/pedal_to_motor_drive_mapper_test.sv
// Top of the pedal mapper testbench: clock, reset, stimulus, receiver and verdict.
module pedal_to_motor_drive_mapper_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pmd_pkg::*;

  logic                    clk = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
  logic [CFG_BITS-1:0]     cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    cmd_valid = 1'b0;
  logic [7:0]              cmd_byte = '0;
  logic [SAMPLE_BITS-1:0]  fwd_sample = '0;
  logic [SAMPLE_BITS-1:0]  rev_sample = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [DUTY_BITS-1:0]    fwd_duty;
  logic [DUTY_BITS-1:0]    rev_duty;
  logic [1:0]              led_state;
  logic [1:0]              mode_out;

  int fail_count;
  int pending;

  // shared between stimulus and receiver
  bit no_idle  = 1'b0;   // both sides run flat out while set
  bit hold_req = 1'b0;   // asks the receiver for one long hold-off
  // the word on the input channel was taken at the last rising edge
  logic in_taken;

  // current ramp, kept so samples can be aimed at its corners
  int cur_off  = 205;
  int cur_full = 767;

  pedal_to_motor_drive_mapper dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .cmd_valid_i  (cmd_valid),
    .cmd_byte_i   (cmd_byte),
    .fwd_sample_i (fwd_sample),
    .rev_sample_i (rev_sample),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .fwd_duty_o   (fwd_duty),
    .rev_duty_o   (rev_duty),
    .led_state_o  (led_state),
    .mode_out_o   (mode_out)
  );

  pmd_drive_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .cmd_valid_i  (cmd_valid),
    .cmd_byte_i   (cmd_byte),
    .fwd_sample_i (fwd_sample),
    .rev_sample_i (rev_sample),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .fwd_duty_i   (fwd_duty),
    .rev_duty_i   (rev_duty),
    .led_state_i  (led_state),
    .mode_out_i   (mode_out),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 12 ns period
  initial begin
    forever begin
      #6 clk = ~clk;
    end
  end

  // Sampled at the rising edge so the driver can look at it at the next
  // falling edge without racing the block's own register updates.
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
    end
  end

  // Overall time limit. The slowest correct run is roughly 1300 words, each
  // slowed by sender gaps, compute and receiver stalls, plus the hold-off and
  // the drain pauses: well under 1 ms. Allow 6 ms.
  initial begin
    #6_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: random stalls, a quiet stretch, and one long hold-off that it
  // counts itself so the block backs up and drops in_ready.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 32);
      end
    end
  end

  // Offer one word and hold it until taken. Entered and left at a falling
  // edge; valid stays high across back-to-back words.
  task automatic send_word(input logic cv, input logic [7:0] cb,
                           input logic [SAMPLE_BITS-1:0] fs,
                           input logic [SAMPLE_BITS-1:0] rs);
    while (!no_idle && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    cmd_valid  <= cv;
    cmd_byte   <= cb;
    fwd_sample <= fs;
    rev_sample <= rs;
    do begin
      @(negedge clk);
    end while (!in_taken);
  endtask

  // Wait until every word has come back, then let the pipeline settle.
  task automatic drain_words();
    in_valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_BITS'(data);
    @(negedge clk);
  endtask

  // Reprogram the whole ramp; only ever done with the block idle.
  // Duty values may carry bits above the register width on purpose.
  task automatic program_ramp(input int off, input int full, input int mn, input int mx);
    drain_words();
    write_reg(REG_OFF_THRESHOLD, off);
    write_reg(REG_FULL_POINT, full);
    write_reg(REG_MIN_DUTY, mn);
    write_reg(REG_MAX_DUTY, mx);
    cfg_we   <= 1'b0;
    cur_off  = off & 10'h3FF;
    cur_full = full & 10'h3FF;
  endtask

  // Mostly aimed at the ramp corners, where off-by-one bugs live.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = 1023;
      2, 3:    v = cur_off + $urandom_range(0, 6) - 3;
      4, 5:    v = cur_full + $urandom_range(0, 6) - 3;
      default: v = $urandom_range(0, 1023);
    endcase
    if (v < 0) begin
      v = 0;
    end
    if (v > 1023) begin
      v = 1023;
    end
    return SAMPLE_BITS'(v);
  endfunction

  initial begin : stimulus
    int         p;
    int         n;
    int         o;
    int         f;
    logic       cv;
    logic [7:0] cb;

    repeat (11) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // --- directed words, reset ramp 205..767, duty 127..255 ---
    send_word(1'b0, 8'h00, 0, 0);            // both pedals off: idle
    send_word(1'b0, 8'hFF, 1023, 1023);      // both full: forward wins
    send_word(1'b0, 8'h00, 204, 0);          // one below threshold
    send_word(1'b0, 8'h00, 205, 0);          // exactly at threshold: min duty
    send_word(1'b0, 8'h00, 766, 0);          // last interpolated step
    send_word(1'b0, 8'h00, 0, 767);          // reverse only at full point
    send_word(1'b0, 8'h00, 500, 600);        // both on the ramp
    send_word(1'b1, CMD_FWD, 1023, 1023);    // forced forward
    send_word(1'b1, CMD_REV | CASE_DELTA, 0, 0);   // lower case r
    send_word(1'b1, CMD_STOP | CASE_DELTA, 900, 900);
    send_word(1'b1, CMD_ANALOG | CASE_DELTA, 300, 0);
    send_word(1'b0, CMD_FWD, 300, 0);        // command byte without cmd_valid
    send_word(1'b1, CMD_FWD | 8'h80, 0, 400);  // high bit set: not a command
    send_word(1'b1, 8'h00, 0, 1023);         // unknown byte
    // threshold equal to full point: no ramp at all
    program_ramp(600, 600, 127, 255);
    send_word(1'b0, 8'h00, 599, 600);
    send_word(1'b0, 8'h00, 600, 599);
    // threshold above full point
    program_ramp(1023, 0, 10, 200);
    send_word(1'b0, 8'h00, 1022, 1023);
    // minimum above maximum: ramp runs downward
    program_ramp(0, 1023, 200, 10);
    send_word(1'b0, 8'h00, 512, 1);
    send_word(1'b0, 8'h00, 0, 1022);
    // zero minimum: at the threshold the pedal counts as inactive
    program_ramp(100, 900, 0, 255);
    send_word(1'b0, 8'h00, 100, 100);
    send_word(1'b0, 8'h00, 101, 0);

    // --- random phases, each with its own ramp ---
    for (p = 0; p < 10; p++) begin
      case (p)
        0: program_ramp(int'(RST_OFF_THRESHOLD), int'(RST_FULL_POINT),
                        int'(RST_MIN_DUTY), int'(RST_MAX_DUTY));
        2: program_ramp(0, 1023, 0, 255);
        3: begin
          program_ramp($urandom_range(0, 400), $urandom_range(600, 1023),
                       $urandom_range(128, 255), $urandom_range(0, 127));
        end
        4: begin
          f = $urandom_range(0, 1000);
          program_ramp($urandom_range(f, 1023), f, $urandom_range(0, 1023),
                       $urandom_range(0, 1023));
        end
        5: begin
          o = $urandom_range(0, 1018);
          program_ramp(o, o + $urandom_range(1, 5), $urandom_range(0, 255),
                       $urandom_range(0, 255));
        end
        6: program_ramp(100, 1000, 0, 255);
        8: program_ramp(0, 1023, 255, 0);
        default: begin
          program_ramp($urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 1023), $urandom_range(0, 1023));
        end
      endcase
      no_idle = (p == 6);
      // receiver stops for a long while; the sender keeps offering
      if (p == 3) begin
        hold_req = 1'b1;
      end
      for (n = 0; n < 125; n++) begin
        cv = ($urandom_range(0, 99) < 12);
        if ($urandom_range(0, 1)) begin
          cb = 8'($urandom_range(0, 255));
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: cb = CMD_ANALOG;
            5, 6:          cb = CMD_FWD;
            7, 8:          cb = CMD_REV;
            default:       cb = CMD_STOP;
          endcase
          if ($urandom_range(0, 1)) begin
            cb = cb | CASE_DELTA;
          end
        end
        send_word(cv, cb, pick_sample(), pick_sample());
      end
    end

    drain_words();
    no_idle = 1'b0;
    repeat (30) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: pedal_to_motor_drive_mapper.f
+incdir+sv
sv/pmd_pkg.sv
sv/pmd_lane.sv
sv/pmd_merge.sv
sv/pedal_to_motor_drive_mapper.sv
tb/pmd_drive_checker.sv
tb/pedal_to_motor_drive_mapper_test.sv
